// ===== hdl/arc_pkg.sv =====
// Package with shared constants, types and encodings of the ARP resolver cache.
package arc_pkg;

	localparam int CacheEntries   = 16;
	localparam int PendingEntries = 8;
	localparam int CacheIdxW      = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
	localparam int PendIdxW       = (PendingEntries > 1) ? $clog2(PendingEntries) : 1;

	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_RECV = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [1:0] FT_IPV4 = 2'd0;
	localparam logic [1:0] FT_ARP  = 2'd1;

	localparam logic [1:0] ACT_IPV4    = 2'd0;
	localparam logic [1:0] ACT_REQUEST = 2'd1;
	localparam logic [1:0] ACT_REPLY   = 2'd2;
	localparam logic [1:0] ACT_DELIVER = 2'd3;

	localparam logic [1:0] REG_OWN_MAC  = 2'd0;
	localparam logic [1:0] REG_OWN_IP   = 2'd1;
	localparam logic [1:0] REG_RETRY    = 2'd2;
	localparam logic [1:0] REG_LIFETIME = 2'd3;

	localparam logic [47:0] BcastMac = 48'hFFFF_FFFF_FFFF;
	localparam logic [23:0] AgeMax   = 24'hFF_FFFF;

	// Cache memory word: ip, mac, age.
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [23:0] age;
	} cache_word_t;

	// Pending memory word: ip, tag, age.
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] tag;
		logic [23:0] age;
	} pend_word_t;

	localparam int CacheWordW = $bits(cache_word_t);
	localparam int PendWordW  = $bits(pend_word_t);

	// One result word.
	typedef struct packed {
		logic [15:0] out_tag;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
		logic [47:0] eth_dst;
		logic [1:0]  action;
	} result_t;

endpackage

// ===== hdl/arp_resolver_cache.sv =====
// Top level of the ARP resolver cache: sequencer over the cache and pending memories.
//
// Usage: each input word on the s_axis channel is one command (send, received
// frame or tick). The block walks its pending table (8 entries) and then its
// address cache (16 entries), one memory read per cycle from a registered-read
// memory, and updates entries by read-modify-write. It then makes at most one
// decision and writes back the chosen entries. A result is then offered on
// m_axis from the output state. The block takes a new word only in idle, so
// it takes the next word only after the current one is walked, decided and
// written back.
// Result words leave on the m_axis channel through an output register; while
// the receiver stalls, the result is held and the next word may be taken and
// processed up to the point where it has a result of its own to emit.
// Reset clears the valid bits of both tables and loads the register defaults
// (retry 5000 ms, lifetime 30000 ms); the memory contents are not cleared and
// need no clearing pass. Configuration writes go through cfg_we, cfg_index and
// cfg_data and are expected only while the block is idle.
module arp_resolver_cache
	import arc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command, hop_ip, datagram_tag, frame_dst_mac, frame_src_mac,
	// frame_type, payload_parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac,
	// arp_target_ip, elapsed_ms; 278 bits, zero-filled to 280
	input  logic [279:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// action, eth_dst, reply_target_ip, reply_target_mac, out_tag; 146 bits
	// zero-filled to 152
	output logic [151:0] m_axis_tdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PEND  = 3'd1;
	localparam logic [2:0] ST_CACHE = 3'd2;
	localparam logic [2:0] ST_DEC   = 3'd3;
	localparam logic [2:0] ST_WR    = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [PendIdxW:0]  PendLast  = (PendIdxW+1)'(PendingEntries);
	localparam logic [CacheIdxW:0] CacheLast = (CacheIdxW+1)'(CacheEntries);
	localparam logic [PendIdxW:0]  PendStep  = (PendIdxW+1)'(1);
	localparam logic [CacheIdxW:0] CacheStep = (CacheIdxW+1)'(1);

	// Configuration registers.
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [23:0] retry_q, life_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
			retry_q   <= 24'd5000;
			life_q    <= 24'd30000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_MAC:  own_mac_q <= cfg_data;
				REG_OWN_IP:   own_ip_q  <= cfg_data[31:0];
				REG_RETRY:    retry_q   <= cfg_data[23:0];
				REG_LIFETIME: life_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Input word fields.
	logic [1:0]  cmd_q;
	logic [31:0] nh_ip_q;
	logic [15:0] tag_q;
	logic [47:0] dst_q, src_q;
	logic [1:0]  ftype_q;
	logic        ok_q, opc_q;
	logic [31:0] sip_q;
	logic [47:0] smac_q;
	logic [31:0] tip_q;
	logic [15:0] el_q;

	logic [2:0]            state_q;
	logic [PendIdxW:0]     pcnt_q;   // read address counter
	logic [CacheIdxW:0]    ccnt_q;
	logic                  prd_q;    // a read issued last cycle
	logic [PendIdxW-1:0]   prd_idx_q;
	logic                  crd_q;
	logic [CacheIdxW-1:0]  crd_idx_q;

	logic [PendingEntries-1:0] pvalid_q;
	logic [CacheEntries-1:0]   cvalid_q;

	// Scan results.
	logic                 p_hit_q, p_free_q;
	logic [PendIdxW-1:0]  p_hit_idx_q, p_free_idx_q;
	pend_word_t           p_hit_word_q;
	logic                 c_hit_q, c_free_q;
	logic [CacheIdxW-1:0] c_hit_idx_q, c_free_idx_q, c_old_idx_q;
	logic [47:0]          c_hit_mac_q;
	logic [23:0]          c_old_age_q;

	// Write-back plan.
	logic                 pw_q, cw_q;
	logic [PendIdxW-1:0]  pw_idx_q;
	logic [CacheIdxW-1:0] cw_idx_q;
	pend_word_t           pw_word_q;
	cache_word_t          cw_word_q;

	result_t res_q;
	logic    res_pend_q;  // result of current item waiting to go out

	// Memory ports.
	logic                 p_we, c_we;
	logic [PendIdxW-1:0]  p_waddr, p_raddr;
	logic [CacheIdxW-1:0] c_waddr, c_raddr;
	pend_word_t           p_wdata, p_rdata;
	cache_word_t          c_wdata, c_rdata;

	arc_ram #(.Width(PendWordW), .Depth(PendingEntries)) u_pend_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	arc_ram #(.Width(CacheWordW), .Depth(CacheEntries)) u_cache_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign p_raddr = pcnt_q[PendIdxW-1:0];
	assign c_raddr = ccnt_q[CacheIdxW-1:0];

	// Tick updates of the entry just read.
	logic        tick_op;
	logic [24:0] p_sum, c_sum;
	assign tick_op = (cmd_q == CMD_TICK);
	assign p_sum = {1'b0, p_rdata.age} + 25'(el_q);
	assign c_sum = {1'b0, c_rdata.age} + 25'(el_q);

	// Memory writes: ageing during the walk, planned updates in ST_WR.
	always_comb begin
		p_we    = 1'b0;
		p_waddr = prd_idx_q;
		p_wdata = p_rdata;
		c_we    = 1'b0;
		c_waddr = crd_idx_q;
		c_wdata = c_rdata;
		if (state_q == ST_WR) begin
			p_we    = pw_q;
			p_waddr = pw_idx_q;
			p_wdata = pw_word_q;
			c_we    = cw_q;
			c_waddr = cw_idx_q;
			c_wdata = cw_word_q;
		end else begin
			if (tick_op && prd_q && pvalid_q[prd_idx_q]) begin
				p_we = 1'b1;
				p_wdata.age = p_sum[24] ? AgeMax : p_sum[23:0];
			end
			if (tick_op && crd_q && cvalid_q[crd_idx_q] && (c_sum < {1'b0, life_q})) begin
				c_we = 1'b1;
				c_wdata.age = c_sum[23:0];
			end
		end
	end

	// Lookup key for the cache and pending scans.
	logic [31:0] key_ip;
	assign key_ip = (cmd_q == CMD_SEND) ? nh_ip_q : sip_q;

	logic addr_ok;
	assign addr_ok = (dst_q == BcastMac) || (dst_q == own_mac_q);

	// Decision from the scan results: write-backs, valid changes and the result.
	result_t              d_res;
	logic                 d_res_vld, d_pw, d_cw, d_pv_we, d_pv_val;
	logic [PendIdxW-1:0]  d_pw_idx, d_pv_idx;
	logic [CacheIdxW-1:0] d_cw_idx;
	pend_word_t           d_pw_word;
	cache_word_t          d_cw_word;

	always_comb begin
		d_res         = '0;
		d_res_vld     = 1'b0;
		d_pw          = 1'b0;
		d_pw_idx      = p_hit_idx_q;
		d_pw_word     = p_hit_word_q;
		d_pw_word.age = '0;
		d_pv_we       = 1'b0;
		d_pv_idx      = p_hit_idx_q;
		d_pv_val      = 1'b0;
		d_cw          = 1'b0;
		d_cw_idx      = c_hit_q ? c_hit_idx_q : (c_free_q ? c_free_idx_q : c_old_idx_q);
		d_cw_word     = '{ip: sip_q, mac: smac_q, age: '0};
		if (cmd_q == CMD_SEND) begin
			if (c_hit_q) begin
				d_res.action  = ACT_IPV4;
				d_res.eth_dst = c_hit_mac_q;
				d_res.out_tag = tag_q;
				d_res_vld     = 1'b1;
			end else if (p_hit_q) begin
				if (p_hit_word_q.age >= retry_q) begin
					d_pw                  = 1'b1;
					d_res.action          = ACT_REQUEST;
					d_res.eth_dst         = BcastMac;
					d_res.reply_target_ip = nh_ip_q;
					d_res_vld             = 1'b1;
				end
			end else if (p_free_q) begin
				d_pw                  = 1'b1;
				d_pw_idx              = p_free_idx_q;
				d_pw_word             = '{ip: nh_ip_q, tag: tag_q, age: '0};
				d_pv_we               = 1'b1;
				d_pv_idx              = p_free_idx_q;
				d_pv_val              = 1'b1;
				d_res.action          = ACT_REQUEST;
				d_res.eth_dst         = BcastMac;
				d_res.reply_target_ip = nh_ip_q;
				d_res_vld             = 1'b1;
			end
		end else if (cmd_q == CMD_RECV && addr_ok && ok_q) begin
			if (ftype_q == FT_IPV4) begin
				d_res.action = ACT_DELIVER;
				d_res_vld    = 1'b1;
			end else if (ftype_q == FT_ARP) begin
				if (opc_q) begin
					if (p_hit_q) begin
						d_pv_we       = 1'b1;
						d_res.action  = ACT_IPV4;
						d_res.eth_dst = smac_q;
						d_res.out_tag = p_hit_word_q.tag;
						d_res_vld     = 1'b1;
					end
				end else if (tip_q == own_ip_q) begin
					d_res.action           = ACT_REPLY;
					d_res.eth_dst          = src_q;
					d_res.reply_target_ip  = sip_q;
					d_res.reply_target_mac = smac_q;
					d_res_vld              = 1'b1;
				end
				d_cw = 1'b1;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pvalid_q   <= '0;
			cvalid_q   <= '0;
			prd_q      <= 1'b0;
			crd_q      <= 1'b0;
			res_pend_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
			pcnt_q     <= '0;
			ccnt_q     <= '0;
		end else begin
			// Output valid rises when a result enters the output register and drops once taken.
			if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			prd_q <= (state_q == ST_PEND) && (pcnt_q != PendLast);
			crd_q <= (state_q == ST_CACHE) && (ccnt_q != CacheLast);
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_PEND;
						pcnt_q  <= '0;
						ccnt_q  <= '0;
						p_hit_q <= 1'b0; p_free_q <= 1'b0;
						c_hit_q <= 1'b0; c_free_q <= 1'b0;
						c_old_idx_q <= '0; c_old_age_q <= '0;
						p_hit_idx_q <= '0; p_free_idx_q <= '0;
						c_hit_idx_q <= '0; c_free_idx_q <= '0;
					end
				end
				ST_PEND: begin
					if (pcnt_q != PendLast) begin
						prd_idx_q <= pcnt_q[PendIdxW-1:0];
						pcnt_q    <= pcnt_q + PendStep;
					end else if (!prd_q) begin
						state_q <= ST_CACHE;
					end
				end
				ST_CACHE: begin
					if (ccnt_q != CacheLast) begin
						crd_idx_q <= ccnt_q[CacheIdxW-1:0];
						ccnt_q    <= ccnt_q + CacheStep;
					end else if (!crd_q) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q    <= ST_WR;
					res_q      <= d_res;
					res_pend_q <= d_res_vld;
					pw_q       <= d_pw;
					pw_idx_q   <= d_pw_idx;
					pw_word_q  <= d_pw_word;
					cw_q       <= d_cw;
					cw_idx_q   <= d_cw_idx;
					cw_word_q  <= d_cw_word;
					if (d_pv_we) begin
						pvalid_q[d_pv_idx] <= d_pv_val;
					end
					if (d_cw) begin
						cvalid_q[d_cw_idx] <= 1'b1;
					end
				end
				ST_WR:  state_q <= res_pend_q ? ST_OUT : ST_IDLE;
				ST_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						res_pend_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Pending scan on read data.
			if (prd_q && pvalid_q[prd_idx_q]) begin
				if (!p_hit_q && p_rdata.ip == key_ip) begin
					p_hit_q      <= 1'b1;
					p_hit_idx_q  <= prd_idx_q;
					p_hit_word_q <= p_rdata;
				end
			end else if (prd_q && !p_free_q) begin
				p_free_q     <= 1'b1;
				p_free_idx_q <= prd_idx_q;
			end

			// Cache scan on read data; ticks evict expired entries.
			if (crd_q && cvalid_q[crd_idx_q]) begin
				if (tick_op && c_sum >= {1'b0, life_q}) begin
					cvalid_q[crd_idx_q] <= 1'b0;
				end
				if (!c_hit_q && c_rdata.ip == key_ip) begin
					c_hit_q     <= 1'b1;
					c_hit_idx_q <= crd_idx_q;
					c_hit_mac_q <= c_rdata.mac;
				end
				if (c_rdata.age > c_old_age_q || crd_idx_q == '0) begin
					c_old_age_q <= c_rdata.age;
					c_old_idx_q <= crd_idx_q;
				end
			end else if (crd_q && !c_free_q) begin
				c_free_q     <= 1'b1;
				c_free_idx_q <= crd_idx_q;
			end
		end
	end

	// Input capture and output register.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_q   <= s_axis_tdata[1:0];
			nh_ip_q <= s_axis_tdata[33:2];
			tag_q   <= s_axis_tdata[49:34];
			dst_q   <= s_axis_tdata[97:50];
			src_q   <= s_axis_tdata[145:98];
			ftype_q <= s_axis_tdata[147:146];
			ok_q    <= s_axis_tdata[148];
			opc_q   <= s_axis_tdata[149];
			sip_q   <= s_axis_tdata[181:150];
			smac_q  <= s_axis_tdata[229:182];
			tip_q   <= s_axis_tdata[261:230];
			el_q    <= s_axis_tdata[277:262];
		end
		if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= {6'd0, res_q};
		end
	end

	// A result is offered only after a word was processed.
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output state");
	// The block takes no word while walking the cache.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CACHE) |-> !s_axis_tready)
		else $error("ready while walking the cache");
	// Decision leads straight to write-back.
	a_dec_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC) |=> (state_q == ST_WR))
		else $error("write-back skipped");
	// A stalled result word stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

endmodule

// ===== hdl/arc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module arc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                          wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                          rdata
);

	logic [Width-1:0] mem [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
